### sv/assert_macros.svh
// Assertion helpers included by the RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define CHK_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### sv/lht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probing hash table package
// Sizes, operation and status codes, sequencer states and the remainder step.
// ----------------------------------------------------------------------------
package lht_pkg;

	// Table and key sizes.
	localparam int BUCKETS  = 11;
	localparam int KEY_BITS = 32;
	localparam int KEY_W    = 32;
	localparam int KEY_USE  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int SLOT_W   = $clog2(BUCKETS);
	localparam int CNT_W    = $clog2(BUCKETS + 1);
	localparam int LOC_W    = 4;

	// Remainder unit: key bits consumed per cycle.
	localparam int HASH_BITS  = 4;
	localparam int HASH_STEPS = (KEY_USE + HASH_BITS - 1) / HASH_BITS;
	localparam int HSTEP_W    = $clog2(HASH_STEPS + 1);
	localparam int SH_W       = HASH_STEPS * HASH_BITS;

	// Operation codes.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_CLEAR  = 2'd0;
	localparam kind_t KIND_INSERT = 2'd1;
	localparam kind_t KIND_LOOKUP = 2'd2;

	// Status codes.
	typedef logic [1:0] status_t;
	localparam status_t STS_OK   = 2'd0;
	localparam status_t STS_MISS = 2'd1;
	localparam status_t STS_FULL = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_INS,
		S_LOOK,
		S_FIN
	} state_t;

	// One step of the running remainder: shift in HASH_BITS key bits, one
	// compare and subtract per bit keeps the remainder below BUCKETS.
	function automatic logic [SLOT_W-1:0] hash_step(input logic [SLOT_W-1:0] rem,
			input logic [HASH_BITS-1:0] digit);
		logic [SLOT_W:0]   t;
		logic [SLOT_W-1:0] r;
		r = rem;
		for (int i = HASH_BITS - 1; i >= 0; i--) begin
			t = {r, digit[i]};
			if (t >= (SLOT_W + 1)'(BUCKETS)) begin
				t = t - (SLOT_W + 1)'(BUCKETS);
			end
			r = t[SLOT_W-1:0];
		end
		return r;
	endfunction

endpackage

### sv/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Clear goes from the idle state to the finish state and then the output register;
// insert and lookup run the remainder steps, then probe up to 11 slots (lookup also reads
// each key through the registered read port), then load the output register.
// One item at a time; remainder takes 4 key bits, probe walk one slot, per cycle.
// Reset empties the table and the output register; stored keys are not cleared.
// ----------------------------------------------------------------------------
// Linear probing hash table
// Open addressing table with a key mod BUCKETS home slot and forward probing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_probe_hash_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                kind,
	input  logic [lht_pkg::KEY_W-1:0] key,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [lht_pkg::LOC_W-1:0] location
);

	lht_pkg::state_t state_q, state_d;
	lht_pkg::kind_t  kind_q;
	logic [lht_pkg::KEY_USE-1:0] key_q;
	logic [lht_pkg::SH_W-1:0]    key_sh_q;
	logic [lht_pkg::SH_W-1:0]    key_pad;
	logic [lht_pkg::HSTEP_W-1:0] hstep_q;
	logic [lht_pkg::SLOT_W-1:0]  probe_q;
	logic [lht_pkg::SLOT_W-1:0]  probe_nxt;
	logic [lht_pkg::SLOT_W-1:0]  rem_nxt;
	logic [lht_pkg::CNT_W-1:0]   cnt_q;
	logic [lht_pkg::BUCKETS-1:0] used_q;

	// Key store and its registered read port.
	logic [lht_pkg::KEY_USE-1:0] slot_keys [lht_pkg::BUCKETS];
	logic [lht_pkg::KEY_USE-1:0] rd_key_s1;
	logic                        rd_used_s1;
	logic [lht_pkg::SLOT_W-1:0]  rd_slot_s1;
	logic                        rd_vld_s1;

	lht_pkg::status_t           res_status_q;
	logic [lht_pkg::SLOT_W-1:0] res_loc_q;
	logic                       out_valid_q;
	lht_pkg::status_t           status_q;
	logic [lht_pkg::LOC_W-1:0]  location_q;

	logic in_accept;
	logic hash_last;
	logic ins_free;
	logic ins_last;
	logic look_issue;
	logic look_hit;
	logic look_miss;
	logic out_load;

	// Handshake: a new item is taken only when the sequencer is idle.
	assign in_stall  = (state_q != lht_pkg::S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign key_pad   = lht_pkg::SH_W'(key[lht_pkg::KEY_USE-1:0]);

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign location  = location_q;

	// Datapath controls for the remainder unit and the probe walk.
	always_comb begin
		probe_nxt  = (probe_q == lht_pkg::SLOT_W'(lht_pkg::BUCKETS - 1)) ?
			'0 : probe_q + lht_pkg::SLOT_W'(1);
		rem_nxt    = lht_pkg::hash_step(probe_q,
			key_sh_q[lht_pkg::SH_W-1 -: lht_pkg::HASH_BITS]);
		hash_last  = (hstep_q == lht_pkg::HSTEP_W'(lht_pkg::HASH_STEPS - 1));
		ins_free   = !used_q[probe_q];
		ins_last   = (cnt_q == lht_pkg::CNT_W'(lht_pkg::BUCKETS - 1));
		look_issue = (cnt_q != lht_pkg::CNT_W'(lht_pkg::BUCKETS));
		look_hit   = rd_vld_s1 && rd_used_s1 && (rd_key_s1 == key_q);
		look_miss  = rd_vld_s1 && !look_hit && !look_issue;
		out_load   = (state_q == lht_pkg::S_FIN) && (!out_valid_q || !out_stall);
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lht_pkg::S_IDLE: begin
				if (in_accept) begin
					if (kind inside {lht_pkg::KIND_INSERT, lht_pkg::KIND_LOOKUP}) begin
						state_d = lht_pkg::S_HASH;
					end else begin
						state_d = lht_pkg::S_FIN;
					end
				end
			end
			lht_pkg::S_HASH: begin
				if (hash_last) begin
					state_d = (kind_q == lht_pkg::KIND_INSERT) ?
						lht_pkg::S_INS : lht_pkg::S_LOOK;
				end
			end
			lht_pkg::S_INS: begin
				if (ins_free || ins_last) begin
					state_d = lht_pkg::S_FIN;
				end
			end
			lht_pkg::S_LOOK: begin
				if (look_hit || look_miss) begin
					state_d = lht_pkg::S_FIN;
				end
			end
			lht_pkg::S_FIN: begin
				if (out_load) begin
					state_d = lht_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lht_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers: state, used flags, probe count, read valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lht_pkg::S_IDLE;
			used_q    <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == lht_pkg::S_LOOK) && look_issue && !look_hit;
			if (in_accept && kind == lht_pkg::KIND_CLEAR) begin
				used_q <= '0;
			end else if (state_q == lht_pkg::S_INS && ins_free) begin
				used_q[probe_q] <= 1'b1;
			end
			if (state_q == lht_pkg::S_HASH) begin
				cnt_q <= '0;
			end else if (state_q == lht_pkg::S_INS && !ins_free) begin
				cnt_q <= cnt_q + lht_pkg::CNT_W'(1);
			end else if (state_q == lht_pkg::S_LOOK && look_issue) begin
				cnt_q <= cnt_q + lht_pkg::CNT_W'(1);
			end
		end
	end

	// Item registers, remainder accumulation, probe pointer and result.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q       <= kind;
			key_q        <= key[lht_pkg::KEY_USE-1:0];
			key_sh_q     <= key_pad;
			hstep_q      <= '0;
			probe_q      <= '0;
			res_status_q <= lht_pkg::STS_OK;
			res_loc_q    <= '0;
		end else begin
			case (state_q)
				lht_pkg::S_HASH: begin
					key_sh_q <= key_sh_q << lht_pkg::HASH_BITS;
					hstep_q  <= hstep_q + lht_pkg::HSTEP_W'(1);
					probe_q  <= rem_nxt;
				end
				lht_pkg::S_INS: begin
					if (ins_free) begin
						res_status_q <= lht_pkg::STS_OK;
						res_loc_q    <= probe_q;
					end else begin
						probe_q <= probe_nxt;
						if (ins_last) begin
							res_status_q <= lht_pkg::STS_FULL;
							res_loc_q    <= '0;
						end
					end
				end
				lht_pkg::S_LOOK: begin
					if (look_issue) begin
						probe_q <= probe_nxt;
					end
					if (look_hit) begin
						res_status_q <= lht_pkg::STS_OK;
						res_loc_q    <= rd_slot_s1;
					end else if (look_miss) begin
						res_status_q <= lht_pkg::STS_MISS;
						res_loc_q    <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Key store: one write port for inserts, one registered read port for lookups.
	always_ff @(posedge clk) begin
		if (state_q == lht_pkg::S_INS && ins_free) begin
			slot_keys[probe_q] <= key_q;
		end
		rd_key_s1  <= slot_keys[probe_q];
		rd_used_s1 <= used_q[probe_q];
		rd_slot_s1 <= probe_q;
	end

	// Output register: holds a result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q   <= res_status_q;
			location_q <= lht_pkg::LOC_W'(res_loc_q);
		end
	end

	// Checks on the sequencer and the table.
	`CHK_IMPLY(a_cnt_range, 1'b1, cnt_q <= lht_pkg::CNT_W'(lht_pkg::BUCKETS))
	`CHK_NEXT(a_busy_after_accept, in_accept, state_q != lht_pkg::S_IDLE)
	`CHK_NEXT(a_insert_marks, state_q == lht_pkg::S_INS && ins_free, used_q[$past(probe_q)])

endmodule
